>>> hw/rtl/las_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Local alignment score package
// Shared widths, codes, reset values and the word carried down the cell chain.
// ----------------------------------------------------------------------------
package las_pkg;

	// Field widths
	localparam int BASE_W  = 8;
	localparam int SCORE_W = 12;
	localparam int CFG_W   = 4;
	localparam int CIDX_W  = 2;
	// Signed width for one cell update: score plus a 4-bit term, with sign
	localparam int CALC_W  = SCORE_W + 2;

	localparam logic [SCORE_W-1:0] SCORE_MAX = SCORE_W'(4095);

	// Default query store depth
	localparam int DEF_MAX_QUERY = 256;

	// Item kinds
	localparam logic KIND_QUERY  = 1'b0;
	localparam logic KIND_TARGET = 1'b1;

	// Configuration register indexes
	localparam logic [CIDX_W-1:0] CFG_MATCH    = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_MISMATCH = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_GAP      = 2'd2;

	// Configuration reset values, half-units
	localparam logic [CFG_W-1:0] MATCH_RST    = 4'd4;
	localparam logic [CFG_W-1:0] MISMATCH_RST = 4'd1;
	localparam logic [CFG_W-1:0] GAP_RST      = 4'd2;

	typedef struct packed {
		logic [CFG_W-1:0] match_bonus;
		logic [CFG_W-1:0] mismatch_penalty;
		logic [CFG_W-1:0] gap_penalty;
	} cfg_t;

	// Word handed from cell to cell. For a query word, wr marks a store write
	// at the position carried beside it; for a target word, the position carried
	// beside it is the active query length.
	typedef struct packed {
		logic               valid;
		logic               kind;
		logic               last;
		logic               wr;
		logic [BASE_W-1:0]  base;
		logic [SCORE_W-1:0] diag;
		logic [SCORE_W-1:0] up;
		logic [SCORE_W-1:0] best;
	} tok_t;

endpackage

>>> hw/rtl/las_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Local alignment score cell
// Holds one query character and one score column entry; updates the entry
// from each passing target word whose query length covers this cell, and hands the word to the next cell.
// ----------------------------------------------------------------------------
module las_cell
	import las_pkg::*;
#(
	parameter int MAX_QUERY = DEF_MAX_QUERY,
	parameter int CELL_IDX  = 0,
	parameter int POS_W     = $clog2(MAX_QUERY + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  tok_t             tok_in,
	input  logic [POS_W-1:0] pos_in,
	output tok_t             tok_out,
	output logic [POS_W-1:0] pos_out
);

	localparam logic [POS_W-1:0] MY_POS = POS_W'(CELL_IDX);

	logic [BASE_W-1:0]        qchar_q;
	logic [SCORE_W-1:0]       h_q;
	logic                     valid_q;
	tok_t                     word_q;
	logic [POS_W-1:0]         pos_q;

	logic                     hit;
	logic                     load;
	logic                     clr;
	logic signed [CALC_W-1:0] diag_c;
	logic signed [CALC_W-1:0] up_c;
	logic signed [CALC_W-1:0] left_c;
	logic signed [CALC_W-1:0] m1;
	logic signed [CALC_W-1:0] m2;
	logic signed [CALC_W-1:0] m3;
	logic [SCORE_W-1:0]       h_new;
	logic [SCORE_W-1:0]       best_new;
	tok_t                     word_d;

	// Decode what this word does to the cell
	assign hit  = tok_in.valid && (tok_in.kind == KIND_TARGET) && (pos_in > MY_POS);
	assign clr  = tok_in.valid && (tok_in.kind == KIND_QUERY);
	assign load = clr && tok_in.wr && (pos_in == MY_POS);

	// Cell score: best of zero, diagonal plus pair score, and the two gaps
	always_comb begin
		diag_c = $signed(CALC_W'(tok_in.diag));
		if (qchar_q == tok_in.base) begin
			diag_c = diag_c + $signed(CALC_W'(cfg.match_bonus));
		end else begin
			diag_c = diag_c - $signed(CALC_W'(cfg.mismatch_penalty));
		end
		up_c   = $signed(CALC_W'(tok_in.up)) - $signed(CALC_W'(cfg.gap_penalty));
		left_c = $signed(CALC_W'(h_q)) - $signed(CALC_W'(cfg.gap_penalty));
		m1 = (diag_c > $signed(CALC_W'(0))) ? diag_c : $signed(CALC_W'(0));
		m2 = (up_c > m1) ? up_c : m1;
		m3 = (left_c > m2) ? left_c : m2;
		// Saturate at the top of the score range
		if (m3 > $signed(CALC_W'(SCORE_MAX))) begin
			h_new = SCORE_MAX;
		end else begin
			h_new = m3[SCORE_W-1:0];
		end
		best_new = (h_new > tok_in.best) ? h_new : tok_in.best;
	end

	// Store the query character; no reset, a cell is read only once written
	always_ff @(posedge clk) begin
		if (load) begin
			qchar_q <= tok_in.base;
		end
	end

	// Score column entry: clear on a query word and at end of target
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q     <= '0;
			valid_q <= 1'b0;
		end else begin
			valid_q <= tok_in.valid;
			if (clr) begin
				h_q <= '0;
			end else if (hit) begin
				h_q <= tok_in.last ? '0 : h_new;
			end
		end
	end

	// Pass the word through, carrying this cell's scores on a target hit
	always_comb begin
		word_d = tok_in;
		if (hit) begin
			word_d.diag = h_q;
			word_d.up   = h_new;
			word_d.best = best_new;
		end
	end

	// Advance the word to the next cell
	always_ff @(posedge clk) begin
		word_q <= word_d;
		pos_q  <= pos_in;
	end

	always_comb begin
		tok_out       = word_q;
		tok_out.valid = valid_q;
	end

	assign pos_out = pos_q;

endmodule

>>> hw/rtl/local_alignment_score_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Local alignment score unit
// Linear-gap local alignment score over a chain of query cells. Query
// characters load the cells; target characters sweep down the chain, one
// cell per cycle, and the best cell score is reported after the last one.
// ----------------------------------------------------------------------------
//
//  channel   handshake            payload
//  -------   ------------------   ----------------------------------------
//  item      start / busy         kind, base, last
//  result    done (one cycle)     best_score
//  config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  One item is taken every cycle; busy is high only for the first cycle
//  after reset. Each word walks the chain of MAX_QUERY cells one cell a
//  cycle, and done is registered from the last target character as it
//  leaves the last cell. Reset clears the query length, the score column and
//  the running best. Results cannot be stalled: done is a one-cycle strobe.
//
module local_alignment_score_unit
	import las_pkg::*;
#(
	parameter int MAX_QUERY = DEF_MAX_QUERY
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               kind,
	input  logic [BASE_W-1:0]  base,
	input  logic               last,
	output logic               done,
	output logic [SCORE_W-1:0] best_score,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CIDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]   cfg_data
);

	localparam int POS_W = $clog2(MAX_QUERY + 1);
	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_QUERY);

	cfg_t               cfg_q;
	logic               busy_q;
	logic [POS_W-1:0]   len_q;
	logic               load_done_q;
	logic [SCORE_W-1:0] best_q;
	logic               done_q;
	logic [SCORE_W-1:0] best_score_q;

	logic               accept;
	logic [POS_W-1:0]   wr_pos;
	logic               wr_ok;
	logic [SCORE_W-1:0] tail_best;

	tok_t               chain [MAX_QUERY+1];
	logic [POS_W-1:0]   pos_chain [MAX_QUERY+1];

	assign accept    = start && !busy_q;
	assign busy      = busy_q;
	assign cfg_ready = 1'b1;

	// Hold off items for the first cycle out of reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.match_bonus      <= MATCH_RST;
			cfg_q.mismatch_penalty <= MISMATCH_RST;
			cfg_q.gap_penalty      <= GAP_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_MATCH:    cfg_q.match_bonus      <= cfg_data;
				CFG_MISMATCH: cfg_q.mismatch_penalty <= cfg_data;
				CFG_GAP:      cfg_q.gap_penalty      <= cfg_data;
				default:      ;
			endcase
		end
	end

	// Query write position: a finished query restarts at zero
	assign wr_pos = load_done_q ? '0 : len_q;
	assign wr_ok  = wr_pos < POS_MAX;

	// Track query length and the loading flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			load_done_q <= 1'b0;
		end else if (accept && (kind == KIND_QUERY)) begin
			len_q       <= wr_ok ? (wr_pos + POS_W'(1)) : wr_pos;
			load_done_q <= last;
		end
	end

	// Form the word entering the first cell
	always_comb begin
		chain[0].valid = accept;
		chain[0].kind  = kind;
		chain[0].last  = last;
		chain[0].wr    = (kind == KIND_QUERY) && wr_ok;
		chain[0].base  = base;
		chain[0].diag  = '0;
		chain[0].up    = '0;
		chain[0].best  = '0;
		pos_chain[0]   = (kind == KIND_QUERY) ? wr_pos : len_q;
	end

	// Row of query cells
	for (genvar i = 0; i < MAX_QUERY; i++) begin : g_cell
		las_cell #(
			.MAX_QUERY(MAX_QUERY),
			.CELL_IDX (i),
			.POS_W    (POS_W)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cfg    (cfg_q),
			.tok_in (chain[i]),
			.pos_in (pos_chain[i]),
			.tok_out(chain[i+1]),
			.pos_out(pos_chain[i+1])
		);
	end

	assign tail_best = (chain[MAX_QUERY].best > best_q) ? chain[MAX_QUERY].best : best_q;

	// Fold column maxima into the running best; clear it on a query word and report at end of target
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (chain[MAX_QUERY].valid) begin
				if (chain[MAX_QUERY].kind == KIND_QUERY) begin
					best_q <= '0;
				end else if (chain[MAX_QUERY].last) begin
					best_q <= '0;
					done_q <= 1'b1;
				end else begin
					best_q <= tail_best;
				end
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (chain[MAX_QUERY].valid && (chain[MAX_QUERY].kind == KIND_TARGET)
				&& chain[MAX_QUERY].last) begin
			best_score_q <= tail_best;
		end
	end

	assign done       = done_q;
	assign best_score = best_score_q;

endmodule

>>> dv/local_alignment_score_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Local alignment score checker
// Watches the item, result and register channels of the score unit. Keeps its
// own query, score column, running best and weights, predicts the best score
// of each finished target, and compares every reported score with the oldest
// prediction in order.
// ----------------------------------------------------------------------------
module local_alignment_score_checker
	import las_pkg::*;
#(
	parameter int MAX_QUERY = DEF_MAX_QUERY
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic               kind,
	input  logic [BASE_W-1:0]  base,
	input  logic               last,
	input  logic               done,
	input  logic [SCORE_W-1:0] best_score,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [CIDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]   cfg_data,
	output int                 fails,
	output int                 pending
);

	cfg_t               weights;
	logic [BASE_W-1:0]  qry_chars [MAX_QUERY];
	logic [SCORE_W-1:0] score_col [MAX_QUERY];
	int                 qry_len;
	logic               qry_closed;
	logic [SCORE_W-1:0] best_cell;
	logic [SCORE_W-1:0] exp_best [$];
	logic [SCORE_W-1:0] want;
	int                 n_fail;

	// Count a failure; print only the first ten
	function automatic void note_fail(input string msg);
		n_fail++;
		if (n_fail <= 10) begin
			$display("%0t: %s", $time, msg);
		end
	endfunction

	// Drop the partial column and the running best
	task automatic clear_column();
		for (int i = 0; i < MAX_QUERY; i++) begin
			score_col[i] = '0;
		end
		best_cell = '0;
	endtask

	// Fold one target character into the column, top row first
	task automatic sweep_target(input logic [BASE_W-1:0] b);
		int diag, up, left, s, h, g;
		diag = 0;
		up   = 0;
		g    = int'(weights.gap_penalty);
		for (int i = 0; i < qry_len; i++) begin
			left = int'(score_col[i]);
			s    = (qry_chars[i] == b) ? int'(weights.match_bonus)
			                           : -int'(weights.mismatch_penalty);
			h = 0;
			if (diag + s > h) h = diag + s;
			if (up - g > h) h = up - g;
			if (left - g > h) h = left - g;
			if (h > int'(SCORE_MAX)) h = int'(SCORE_MAX);
			score_col[i] = SCORE_W'(h);
			if (SCORE_W'(h) > best_cell) best_cell = SCORE_W'(h);
			diag = left;
			up   = h;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weights    = '{match_bonus: MATCH_RST, mismatch_penalty: MISMATCH_RST,
			               gap_penalty: GAP_RST};
			qry_len    = 0;
			qry_closed = 1'b0;
			n_fail     = 0;
			clear_column();
			exp_best.delete();
			fails   <= 0;
			pending <= 0;
		end else begin
			// Match a reported score against the oldest prediction
			if (done) begin
				if (exp_best.size() == 0) begin
					note_fail($sformatf("best_score %0d with no score expected",
						best_score));
				end else begin
					want = exp_best.pop_front();
					if (best_score !== want) begin
						note_fail($sformatf("best_score expected %0d, got %0d",
							want, best_score));
					end
				end
			end

			// Track register writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_MATCH:    weights.match_bonus      = cfg_data;
					CFG_MISMATCH: weights.mismatch_penalty = cfg_data;
					CFG_GAP:      weights.gap_penalty      = cfg_data;
					default: ;
				endcase
			end

			// Advance the predicted state on each accepted word
			if (start && !busy) begin
				if (kind == KIND_QUERY) begin
					if (qry_closed) begin
						qry_len    = 0;
						qry_closed = 1'b0;
					end
					if (qry_len < MAX_QUERY) begin
						qry_chars[qry_len] = base;
						qry_len++;
					end
					if (last) qry_closed = 1'b1;
					clear_column();
				end else begin
					sweep_target(base);
					if (last) begin
						exp_best.push_back(best_cell);
						clear_column();
					end
				end
			end

			fails   <= n_fail;
			pending <= exp_best.size();
		end
	end

endmodule

>>> dv/local_alignment_score_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Local alignment score unit testbench
// Drives query and target words into the score unit: a directed opening over
// the corner cases, then random query/target sessions under six weight
// settings and three sender idle rates. The checker beside the unit predicts
// and compares; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module local_alignment_score_unit_tb;
	import las_pkg::*;

	localparam int MAX_Q        = DEF_MAX_QUERY;
	// Drain time covers a word's walk down the cell chain, with margin
	localparam int DRAIN_CYCLES = MAX_Q + 16;
	localparam int CYCLE_LIMIT  = 200000;

	logic               clk;
	logic               arst_n    = 1'b0;
	logic               start     = 1'b0;
	logic               kind      = KIND_QUERY;
	logic [BASE_W-1:0]  base      = '0;
	logic               last      = 1'b0;
	logic               cfg_valid = 1'b0;
	logic [CIDX_W-1:0]  cfg_index = CFG_MATCH;
	logic [CFG_W-1:0]   cfg_data  = '0;
	logic               busy;
	logic               done;
	logic               cfg_ready;
	logic [SCORE_W-1:0] best_score;
	int                 fails;
	int                 pending;
	int                 idle_pct  = 22;
	int                 sent      = 0;
	int                 cycles    = 0;
	logic [BASE_W-1:0]  alphabet [4];

	local_alignment_score_unit #(.MAX_QUERY(MAX_Q)) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.kind       (kind),
		.base       (base),
		.last       (last),
		.done       (done),
		.best_score (best_score),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	local_alignment_score_checker #(.MAX_QUERY(MAX_Q)) u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.kind       (kind),
		.base       (base),
		.last       (last),
		.done       (done),
		.best_score (best_score),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fails      (fails),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Offer one word after a random gap; hold it until taken
	task automatic send_word(input logic k, input logic [BASE_W-1:0] b, input logic l);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		kind  <= k;
		base  <= b;
		last  <= l;
		@(posedge clk);
		while (busy) @(posedge clk);
		sent++;
	endtask

	// Hold off until every score is in and the cell chain is empty
	task automatic settle();
		start <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic put_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic load_weights(input logic [CFG_W-1:0] m, input logic [CFG_W-1:0] mm,
			input logic [CFG_W-1:0] g);
		put_reg(CFG_MATCH, m);
		put_reg(CFG_MISMATCH, mm);
		put_reg(CFG_GAP, g);
		cfg_valid <= 1'b0;
	endtask

	// Mostly from the session alphabet so that matches are common
	function automatic logic [BASE_W-1:0] pick_base();
		if ($urandom_range(9) == 0) return BASE_W'($urandom);
		return alphabet[$urandom_range(3)];
	endfunction

	// Random sessions: one query, then one to four targets; some loose words between
	task automatic run_traffic(input int n_words, input bit long_first);
		int  stop_at, q_n, t_n, n_tgt, pick;
		bit  long_q, q_open, cut;
		stop_at = sent + n_words;
		long_q  = long_first;
		while (sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 85) begin
				for (int a = 0; a < 4; a++) alphabet[a] = BASE_W'($urandom);
				if (long_q) q_n = MAX_Q + $urandom_range(1, 4);
				else if (pick < 2) q_n = $urandom_range(MAX_Q - 8, MAX_Q);
				else if (pick < 14) q_n = $urandom_range(13, 40);
				else q_n = $urandom_range(1, 12);
				long_q = 1'b0;
				// leave some queries open so targets see a partial query
				q_open = ($urandom_range(9) == 0);
				for (int i = 0; i < q_n; i++) begin
					send_word(KIND_QUERY, pick_base(), (i == q_n - 1) && !q_open);
				end
				n_tgt = $urandom_range(1, 4);
				for (int t = 0; t < n_tgt; t++) begin
					t_n = $urandom_range(1, 16);
					// cut the odd target short; a later query drops it
					cut = (t == n_tgt - 1) && ($urandom_range(9) == 0);
					for (int j = 0; j < t_n; j++) begin
						send_word(KIND_TARGET, pick_base(), (j == t_n - 1) && !cut);
					end
				end
			end else begin
				send_word(1'($urandom_range(1)), BASE_W'($urandom), 1'($urandom_range(1)));
			end
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty query scores zero
		send_word(KIND_TARGET, 8'h00, 1'b1);
		// Target against a query still being loaded
		send_word(KIND_QUERY, 8'h41, 1'b0);
		send_word(KIND_TARGET, 8'h41, 1'b1);
		// Finish the same query, then a two-character match
		send_word(KIND_QUERY, 8'h43, 1'b1);
		send_word(KIND_TARGET, 8'h41, 1'b0);
		send_word(KIND_TARGET, 8'h43, 1'b1);
		// New query after a closed one; base extremes
		send_word(KIND_QUERY, 8'h00, 1'b0);
		send_word(KIND_QUERY, 8'hFF, 1'b1);
		send_word(KIND_TARGET, 8'h00, 1'b0);
		send_word(KIND_TARGET, 8'hFF, 1'b1);
		send_word(KIND_TARGET, 8'hFF, 1'b0);
		send_word(KIND_TARGET, 8'h00, 1'b1);
		// Query word in the middle of a target abandons it
		send_word(KIND_TARGET, 8'h00, 1'b0);
		send_word(KIND_QUERY, 8'h00, 1'b1);
		send_word(KIND_TARGET, 8'h00, 1'b1);
		// Mismatches first, then a match on the last character
		send_word(KIND_TARGET, 8'h12, 1'b0);
		send_word(KIND_TARGET, 8'h34, 1'b0);
		send_word(KIND_TARGET, 8'h00, 1'b1);

		for (int seg = 0; seg < 6; seg++) begin
			settle();
			case (seg)
				0: load_weights(4'd15, 4'd0, 4'd0);
				1: load_weights(4'd0, 4'd15, 4'd15);
				2: load_weights(4'd15, 4'd15, 4'd15);
				3: load_weights(4'd0, 4'd0, 4'd0);
				4: load_weights(CFG_W'($urandom_range(15)), CFG_W'($urandom_range(15)),
					CFG_W'($urandom_range(15)));
				default: load_weights(MATCH_RST, MISMATCH_RST, GAP_RST);
			endcase
			idle_pct = (seg < 2) ? 22 : (seg < 4) ? 77 : 0;
			run_traffic(150, seg == 0);
		end
		settle();

		if (fails == 0 && pending == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
